### sv/file_receive_sequence_crc_checker_defines.svh
// Assertion macros for the file receive checker.
// Included by the modules that carry concurrent checks; expects clk and rst in scope.
`ifndef FILE_RECEIVE_SEQUENCE_CRC_CHECKER_DEFINES_SVH
`define FILE_RECEIVE_SEQUENCE_CRC_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FCRC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcrc check failed in %m");

// Next-cycle implication, disabled during reset
`define FCRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcrc check failed in %m");

`endif

### sv/fcrc_pkg.sv
// Shared types, codes and the CRC-16 byte update for the file receive checker.
// No dependencies; used by fcrc_cfg_regs and the top level.
package fcrc_pkg;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam int ADDR_W   = 4;

  // Input kinds
  localparam logic [KIND_W-1:0] KIND_START = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CHUNK = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DATA  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ABORT = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_BIG   = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_SEQ_ERR   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_CRC_ERR   = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 3'd5;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_CRC_INIT  = 2'd0;
  localparam logic [1:0] REG_CRC_XOR   = 2'd1;
  localparam logic [1:0] REG_MAX_BYTES = 2'd2;

  localparam logic [15:0] CRC_INIT_RST  = 16'hFFFF;
  localparam logic [15:0] CRC_XOR_RST   = 16'h0000;
  localparam logic [31:0] MAX_BYTES_RST = 32'd16777216;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  PKT_WRAP = 8'd255;

  typedef struct packed {
    logic [15:0] crc_init;
    logic [15:0] crc_xor;
    logic [31:0] max_bytes;
  } cfg_t;

  // CRC-16-CCITT, MSB first, one byte unrolled over eight bit steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### sv/fcrc_cfg_regs.sv
// APB-style configuration registers of the file receive checker.
// Depends on fcrc_pkg for register indexes, reset values and cfg_t.
module fcrc_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fcrc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output fcrc_pkg::cfg_t             cfg
);
  import fcrc_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crc_init  <= CRC_INIT_RST;
      cfg.crc_xor   <= CRC_XOR_RST;
      cfg.max_bytes <= MAX_BYTES_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CRC_INIT:  cfg.crc_init  <= pwdata[15:0];
        REG_CRC_XOR:   cfg.crc_xor   <= pwdata[15:0];
        REG_MAX_BYTES: cfg.max_bytes <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      REG_CRC_INIT:  prdata = {16'h0000, cfg.crc_init};
      REG_CRC_XOR:   prdata = {16'h0000, cfg.crc_xor};
      REG_MAX_BYTES: prdata = cfg.max_bytes;
      default:       prdata = 32'h0000_0000;
    endcase
  end

endmodule

### sv/file_receive_sequence_crc_checker.sv
// An accepted transaction is held in the input register and checked from there; its result
// is registered into the output register and shows on m_tvalid. Throughput: one transaction
// per cycle unless m_tready stalls; the input register, the single-pass check and CRC update,
// and the output register form the path, and session state is written once per item.
// While a result waits on a stalled master side, the input side takes one more transaction
// into the input register and then holds s_tready low until m_tready returns.
// Reset (rst, synchronous, active high): session state clears to zero, registers to defaults.
// Top level of the file receive checker; depends on fcrc_pkg, fcrc_cfg_regs and the
// assertion macros in file_receive_sequence_crc_checker_defines.svh.
module file_receive_sequence_crc_checker (
  input  logic                        clk,
  input  logic                        rst,
  // Slave side: tdata = total_size[31:0], packet_number[39:32], chunk_length[55:40],
  // data_byte[63:56], sender_crc[79:64]; tuser = kind[2:0]
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [79:0]                 s_tdata,
  input  logic [2:0]                  s_tuser,
  // Master side: tdata = status[2:0], delete_on_close[3], byte_count[35:4],
  // last_sequence[43:36], zero[47:44]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [47:0]                 m_tdata,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcrc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fcrc_pkg::*;
  `include "file_receive_sequence_crc_checker_defines.svh"

  cfg_t cfg;

  fcrc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register
  logic              in_valid;
  logic [KIND_W-1:0] in_kind;
  logic [31:0]       in_total;
  logic [7:0]        in_pkt;
  logic [15:0]       in_len;
  logic [7:0]        in_byte;
  logic [15:0]       in_scrc;

  // Session state
  logic [7:0]  prev_packet;
  logic [31:0] bytes_so_far;
  logic [15:0] crc_acc;
  logic        delete_flag;
  logic [15:0] chunk_left;

  logic [7:0]          prev_packet_next;
  logic [31:0]         bytes_so_far_next;
  logic [15:0]         crc_acc_next;
  logic                delete_flag_next;
  logic [15:0]         chunk_left_next;
  logic [STATUS_W-1:0] status_next;

  // Output register
  logic [STATUS_W-1:0] out_status;
  logic                out_delete;
  logic [31:0]         out_bytes;
  logic [7:0]          out_seq;

  logic        fire;
  logic        s_accept;
  logic [7:0]  expected_pkt;
  logic [32:0] sum_bytes;
  logic        over_limit;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;
  assign s_accept = s_tvalid && s_tready;

  // Capture an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_kind  <= s_tuser;
      in_total <= s_tdata[31:0];
      in_pkt   <= s_tdata[39:32];
      in_len   <= s_tdata[55:40];
      in_byte  <= s_tdata[63:56];
      in_scrc  <= s_tdata[79:64];
    end
  end

  // Check the item against the session and work out the next state
  assign expected_pkt = ((prev_packet == 8'd0) || (prev_packet == PKT_WRAP)) ?
                        8'd1 : prev_packet + 8'd1;
  assign sum_bytes    = {1'b0, bytes_so_far} + {17'd0, in_len};
  assign over_limit   = sum_bytes > {1'b0, cfg.max_bytes};

  always_comb begin
    prev_packet_next  = prev_packet;
    bytes_so_far_next = bytes_so_far;
    crc_acc_next      = crc_acc;
    delete_flag_next  = delete_flag;
    chunk_left_next   = chunk_left;
    status_next       = STATUS_OK;
    case (in_kind)
      KIND_START: begin
        if (in_total > cfg.max_bytes) begin
          status_next = STATUS_TOO_BIG;
        end else begin
          prev_packet_next  = 8'd0;
          bytes_so_far_next = 32'd0;
          crc_acc_next      = cfg.crc_init;
          delete_flag_next  = 1'b0;
          chunk_left_next   = 16'd0;
        end
      end
      KIND_CHUNK: begin
        if (in_pkt != expected_pkt) begin
          status_next     = STATUS_SEQ_ERR;
          chunk_left_next = 16'd0;
        end else if (over_limit) begin
          status_next     = STATUS_OVERFLOW;
          chunk_left_next = 16'd0;
        end else begin
          bytes_so_far_next = sum_bytes[31:0];
          prev_packet_next  = in_pkt;
          chunk_left_next   = in_len;
        end
      end
      KIND_DATA: begin
        if (chunk_left != 16'd0) begin
          crc_acc_next    = crc16_byte(crc_acc, in_byte);
          chunk_left_next = chunk_left - 16'd1;
        end else begin
          status_next = STATUS_IGNORED;
        end
      end
      KIND_END: begin
        if ((crc_acc ^ cfg.crc_xor) != in_scrc) begin
          delete_flag_next = 1'b1;
          status_next      = STATUS_CRC_ERR;
        end
      end
      KIND_ABORT: begin
        delete_flag_next = 1'b1;
      end
      default: ;
    endcase
  end

  // Advance session state once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_packet  <= 8'd0;
      bytes_so_far <= 32'd0;
      crc_acc      <= 16'd0;
      delete_flag  <= 1'b0;
      chunk_left   <= 16'd0;
    end else if (fire) begin
      prev_packet  <= prev_packet_next;
      bytes_so_far <= bytes_so_far_next;
      crc_acc      <= crc_acc_next;
      delete_flag  <= delete_flag_next;
      chunk_left   <= chunk_left_next;
    end
  end

  // Hold the result until the master side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= status_next;
      out_delete <= delete_flag_next;
      out_bytes  <= bytes_so_far_next;
      out_seq    <= prev_packet_next;
    end
  end

  assign m_tdata = {4'h0, out_seq, out_bytes, out_delete, out_status};

  // A processed item always leaves a result behind it
  `FCRC_ASSERT_NEXT(a_fire_gives_result, fire, m_tvalid)
  // An empty chunk budget makes a data byte come back ignored
  `FCRC_ASSERT_NEXT(a_byte_ignored, fire && (in_kind == KIND_DATA) && (chunk_left == 16'd0), out_status == STATUS_IGNORED)
  // Bytes pending means a chunk was accepted in this session
  `FCRC_ASSERT_SAME(a_left_needs_seq, chunk_left != 16'd0, prev_packet != 8'd0)
  // An abort always reports the file for deletion
  `FCRC_ASSERT_NEXT(a_abort_deletes, fire && (in_kind == KIND_ABORT), out_delete && (out_status == STATUS_OK))
  // The input register drains when processed and nothing new comes in
  `FCRC_ASSERT_NEXT(a_in_drains, fire && !s_accept, !in_valid)

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the file receive checker: directed table, then session traffic.
// Depends on fcrc_pkg and file_receive_sequence_crc_checker; predicts every result in-line.
module testbench;
  import fcrc_pkg::*;

  // Reserved kinds that the block must ignore
  localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;
  localparam int LAT_CYCLES = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] total;
    logic [7:0]  pkt;
    logic [15:0] len;
    logic [7:0]  dbyte;
    logic [15:0] scrc;
  } rx_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        del_close;
    logic [31:0] byte_cnt;
    logic [7:0]  last_seq;
  } rx_result_t;

  typedef struct packed {
    logic       is_wr;
    logic [1:0] wr_reg;
    logic [31:0] wr_val;
    rx_item_t   item;
    logic       typed;
    rx_result_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of configuration and session state
  logic [15:0] crc_seed = CRC_INIT_RST;
  logic [15:0] crc_xor = CRC_XOR_RST;
  logic [31:0] max_bytes = MAX_BYTES_RST;
  logic [7:0]  last_pkt = '0;
  logic [31:0] byte_total = '0;
  logic [15:0] crc_acc = '0;
  logic        del_flag = 1'b0;
  logic [15:0] chunk_left = '0;

  rx_result_t pending_results[$];
  int fail_count = 0;
  int n_sent = 0;
  int n_wr = 0;
  int n_checked = 0;
  int st_seen[8];
  int src_calm = 0;
  int sink_calm = 0;
  int sink_hold = 0;

  file_receive_sequence_crc_checker u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // total_size, packet_number, chunk_length, data_byte, sender_crc
    .s_tuser  (s_tuser),   // kind
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // status, delete_on_close, byte_count, last_sequence, zero pad
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Mostly no gap, some short ones, a few long; occasionally a calm stretch with none
  function automatic int pick_gap(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 62) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // MSB-first CRC-16 over one byte, one bit per step
  function automatic logic [15:0] crc_fold_byte(logic [15:0] crc, logic [7:0] d);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = crc[15] ^ d[k];
      crc = {crc[14:0], 1'b0};
      if (fb) crc = crc ^ CRC_POLY;
    end
    return crc;
  endfunction

  function automatic logic [7:0] next_pkt();
    return (last_pkt == 8'd0 || last_pkt == PKT_WRAP) ? 8'd1 : last_pkt + 8'd1;
  endfunction

  // Advance the session state by one transaction and return its result.
  // The announced size only matters to the start check, so it is not kept.
  function automatic rx_result_t predict_receive(rx_item_t it);
    rx_result_t r;
    logic [32:0] sum;
    r = '0;
    r.status = STATUS_OK;
    sum = {1'b0, byte_total} + it.len;
    case (it.kind)
      KIND_START: begin
        if (it.total > max_bytes) begin
          r.status = STATUS_TOO_BIG;
        end else begin
          last_pkt = '0;
          byte_total = '0;
          crc_acc = crc_seed;
          del_flag = 1'b0;
          chunk_left = '0;
        end
      end
      KIND_CHUNK: begin
        if (it.pkt != next_pkt()) begin
          r.status = STATUS_SEQ_ERR;
          chunk_left = '0;
        end else if (sum > {1'b0, max_bytes}) begin
          r.status = STATUS_OVERFLOW;
          chunk_left = '0;
        end else begin
          byte_total = sum[31:0];
          last_pkt = it.pkt;
          chunk_left = it.len;
        end
      end
      KIND_DATA: begin
        if (chunk_left != 0) begin
          crc_acc = crc_fold_byte(crc_acc, it.dbyte);
          chunk_left = chunk_left - 16'd1;
        end else begin
          r.status = STATUS_IGNORED;
        end
      end
      KIND_END: begin
        if ((crc_acc ^ crc_xor) != it.scrc) begin
          del_flag = 1'b1;
          r.status = STATUS_CRC_ERR;
        end
      end
      KIND_ABORT: del_flag = 1'b1;
      default: ;
    endcase
    r.del_close = del_flag;
    r.byte_cnt = byte_total;
    r.last_seq = last_pkt;
    return r;
  endfunction

  function automatic rx_item_t mk_item(logic [2:0] kind, logic [31:0] total, logic [7:0] pkt,
                                       logic [15:0] len, logic [7:0] dbyte, logic [15:0] scrc);
    rx_item_t it;
    it = '{kind, total, pkt, len, dbyte, scrc};
    return it;
  endfunction

  function automatic rx_result_t mk_res(logic [2:0] status, logic del_close,
                                        logic [31:0] byte_cnt, logic [7:0] last_seq);
    rx_result_t r;
    r = '{status, del_close, byte_cnt, last_seq};
    return r;
  endfunction

  function automatic dir_row_t row_chk(rx_item_t it, rx_result_t want);
    dir_row_t d;
    d = '{1'b0, 2'd0, 32'd0, it, 1'b1, want};
    return d;
  endfunction

  function automatic dir_row_t row_pred(rx_item_t it);
    dir_row_t d;
    d = '{1'b0, 2'd0, 32'd0, it, 1'b0, '0};
    return d;
  endfunction

  function automatic dir_row_t row_wr(logic [1:0] idx, logic [31:0] val);
    dir_row_t d;
    d = '{1'b1, idx, val, '0, 1'b0, '0};
    return d;
  endfunction

  function automatic rx_item_t rand_item();
    rx_item_t it;
    it.kind = $urandom_range(0, 7);
    it.total = $urandom;
    it.pkt = $urandom_range(0, 255);
    it.len = $urandom_range(0, 16'hFFFF);
    it.dbyte = $urandom_range(0, 255);
    it.scrc = $urandom_range(0, 16'hFFFF);
    return it;
  endfunction

  // Present one transaction after a random gap, hold until accepted, then queue its result
  task automatic send_item(input rx_item_t it, input logic typed = 1'b0,
                           input rx_result_t want = '0);
    int gap;
    rx_result_t r;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {it.scrc, it.dbyte, it.len, it.pkt, it.total};
    s_tuser <= it.kind;
    do @(posedge clk); while (!s_tready);
    r = predict_receive(it);
    pending_results.push_back(typed ? want : r);
    n_sent++;
  endtask

  // Drop valid and let every outstanding result drain
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CRC_INIT:  crc_seed = val[15:0];
      REG_CRC_XOR:   crc_xor = val[15:0];
      REG_MAX_BYTES: max_bytes = val;
      default: ;
    endcase
    n_wr++;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] seed, input logic [15:0] fxor,
                            input logic [31:0] lim);
    wait_idle();
    write_reg(REG_CRC_INIT, {16'd0, seed});
    write_reg(REG_CRC_XOR, {16'd0, fxor});
    write_reg(REG_MAX_BYTES, lim);
  endtask

  // One file transfer: start, chunks with their bytes, then end or abort; with some breakage
  task automatic file_session(input int n_chunks, input logic tiny);
    rx_item_t it;
    int nb;
    int r;
    it = rand_item();
    it.kind = KIND_START;
    if ($urandom_range(0, 99) < 85) it.total = $urandom_range(0, max_bytes);
    send_item(it);
    repeat (n_chunks) begin
      it = rand_item();
      it.kind = KIND_CHUNK;
      if ($urandom_range(0, 99) >= 8) it.pkt = next_pkt();
      r = $urandom_range(0, 99);
      if (tiny) it.len = ($urandom_range(0, 3) == 0);
      else if (r < 70) it.len = $urandom_range(0, 12);
      else if (r < 90) it.len = $urandom_range(13, 64);
      send_item(it);
      nb = (it.len > 64) ? $urandom_range(0, 8) : it.len;
      if (!tiny && $urandom_range(0, 9) == 0)
        nb = (nb > 0 && $urandom_range(0, 1)) ? nb - 1 : nb + $urandom_range(1, 2);
      repeat (nb) begin
        it = rand_item();
        it.kind = KIND_DATA;
        send_item(it);
      end
    end
    it = rand_item();
    r = $urandom_range(0, 99);
    if (r < 70) begin
      it.kind = KIND_END;
      it.scrc = crc_acc ^ crc_xor;
    end else if (r < 88) begin
      it.kind = KIND_END;
    end else begin
      it.kind = KIND_ABORT;
    end
    send_item(it);
  endtask

  task automatic random_mix(input int n);
    int stop;
    stop = n_sent + n;
    while (n_sent < stop) begin
      if ($urandom_range(0, 99) < 80) file_session($urandom_range(1, 5), 1'b0);
      else send_item(rand_item());
    end
  endtask

  // Downstream stalls
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_tready <= 1'b1;
      sink_hold = pick_gap(sink_calm);
    end
  end

  // Compare each delivered result with the oldest expectation
  always @(posedge clk) begin : result_check
    rx_result_t got;
    rx_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[2:0], m_tdata[3], m_tdata[35:4], m_tdata[43:36]};
      st_seen[got.status]++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d delete %0d bytes %0d seq %0d",
                 $time, got.status, got.del_close, got.byte_cnt, got.last_seq);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got !== want) begin
          $display("%0t: mismatch: expected status %0d delete %0d bytes %0d seq %0d, %s",
                   $time, want.status, want.del_close, want.byte_cnt, want.last_seq,
                   $sformatf("got status %0d delete %0d bytes %0d seq %0d",
                             got.status, got.del_close, got.byte_cnt, got.last_seq));
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t rows[$];
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table at reset configuration, then a tight byte limit with zero seed
    rows.push_back(row_chk(mk_item(KIND_DATA, 0, 0, 0, 8'h3C, 0),
                           mk_res(STATUS_IGNORED, 0, 0, 0)));
    rows.push_back(row_chk(mk_item(KIND_END, 0, 0, 0, 0, 16'h0000),
                           mk_res(STATUS_OK, 0, 0, 0)));
    rows.push_back(row_chk(mk_item(KIND_CHUNK, 0, 8'd1, 16'd0, 0, 0),
                           mk_res(STATUS_OK, 0, 0, 8'd1)));
    rows.push_back(row_chk(mk_item(KIND_START, 32'd16777217, 0, 0, 0, 0),
                           mk_res(STATUS_TOO_BIG, 0, 0, 8'd1)));
    rows.push_back(row_chk(mk_item(KIND_START, 32'd16777216, 0, 0, 0, 0),
                           mk_res(STATUS_OK, 0, 0, 0)));
    rows.push_back(row_chk(mk_item(KIND_CHUNK, 0, 8'd2, 16'd5, 0, 0),
                           mk_res(STATUS_SEQ_ERR, 0, 0, 0)));
    rows.push_back(row_chk(mk_item(KIND_CHUNK, 0, 8'd0, 16'd5, 0, 0),
                           mk_res(STATUS_SEQ_ERR, 0, 0, 0)));
    rows.push_back(row_chk(mk_item(KIND_CHUNK, 0, 8'd1, 16'hFFFF, 0, 0),
                           mk_res(STATUS_OK, 0, 32'd65535, 8'd1)));
    rows.push_back(row_pred(mk_item(KIND_DATA, 0, 0, 0, 8'h00, 0)));
    rows.push_back(row_pred(mk_item(KIND_DATA, 0, 0, 0, 8'hFF, 0)));
    rows.push_back(row_pred(mk_item(KIND_DATA, 0, 0, 0, 8'hA5, 0)));
    // A rejected chunk clears the remaining byte budget
    rows.push_back(row_chk(mk_item(KIND_CHUNK, 0, 8'd3, 16'd1, 0, 0),
                           mk_res(STATUS_SEQ_ERR, 0, 32'd65535, 8'd1)));
    rows.push_back(row_chk(mk_item(KIND_DATA, 0, 0, 0, 8'h5A, 0),
                           mk_res(STATUS_IGNORED, 0, 32'd65535, 8'd1)));
    rows.push_back(row_pred(mk_item(KIND_END, 0, 0, 0, 0, 16'hFFFF)));
    rows.push_back(row_chk(mk_item(KIND_ABORT, 0, 0, 0, 0, 0),
                           mk_res(STATUS_OK, 1, 32'd65535, 8'd1)));
    rows.push_back(row_chk(mk_item(KIND_RSVD_HI, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF,
                                   16'hFFFF), mk_res(STATUS_OK, 1, 32'd65535, 8'd1)));
    rows.push_back(row_chk(mk_item(KIND_RSVD_LO, 0, 0, 0, 0, 0),
                           mk_res(STATUS_OK, 1, 32'd65535, 8'd1)));
    rows.push_back(row_wr(REG_MAX_BYTES, 32'd10));
    rows.push_back(row_wr(REG_CRC_INIT, 32'h0000));
    rows.push_back(row_wr(REG_CRC_XOR, 32'h0000));
    rows.push_back(row_chk(mk_item(KIND_START, 32'hFFFF_FFFF, 0, 0, 0, 0),
                           mk_res(STATUS_TOO_BIG, 1, 32'd65535, 8'd1)));
    rows.push_back(row_chk(mk_item(KIND_START, 32'd10, 0, 0, 0, 0),
                           mk_res(STATUS_OK, 0, 0, 0)));
    rows.push_back(row_chk(mk_item(KIND_CHUNK, 0, 8'd1, 16'd10, 0, 0),
                           mk_res(STATUS_OK, 0, 32'd10, 8'd1)));
    rows.push_back(row_chk(mk_item(KIND_CHUNK, 0, 8'd2, 16'd1, 0, 0),
                           mk_res(STATUS_OVERFLOW, 0, 32'd10, 8'd1)));
    rows.push_back(row_chk(mk_item(KIND_DATA, 0, 0, 0, 8'h81, 0),
                           mk_res(STATUS_IGNORED, 0, 32'd10, 8'd1)));
    rows.push_back(row_chk(mk_item(KIND_END, 0, 0, 0, 0, 16'h0000),
                           mk_res(STATUS_OK, 0, 32'd10, 8'd1)));

    foreach (rows[i]) begin
      if (rows[i].is_wr) begin
        wait_idle();
        write_reg(rows[i].wr_reg, rows[i].wr_val);
      end else begin
        send_item(rows[i].item, rows[i].typed, rows[i].want);
      end
    end

    // Wide-open limit: one long session that wraps the packet number, then mixed traffic
    set_config(16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    file_session(258, 1'b1);
    random_mix(130);

    // Zero limit, inverted seed and final mask
    set_config(16'h0000, 16'hFFFF, 32'd0);
    random_mix(100);

    // Small limit so that chunks overflow often
    set_config($urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
               $urandom_range(16, 400));
    random_mix(180);

    set_config($urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF), $urandom);
    random_mix(130);

    wait_idle();
    $display("Sent %0d transactions, checked %0d results, %0d register writes", n_sent,
             n_checked, n_wr);
    $display("Status seen: ok %0d, too big %0d, sequence %0d, overflow %0d, crc %0d, ignored %0d",
             st_seen[STATUS_OK], st_seen[STATUS_TOO_BIG], st_seen[STATUS_SEQ_ERR],
             st_seen[STATUS_OVERFLOW], st_seen[STATUS_CRC_ERR], st_seen[STATUS_IGNORED]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/fcrc_pkg.sv
sv/fcrc_cfg_regs.sv
sv/file_receive_sequence_crc_checker.sv
dv/testbench.sv
